// ===== hw/rtl/kpsc_pkg.sv =====
// Shared types, constants and key map for the keypad scanner.
`default_nettype none
package kpsc_pkg;

	localparam int ROWS       = 4;
	localparam int COLS       = 4;
	localparam int KEYS       = ROWS * COLS;
	localparam int SETTLE_W   = 4;
	localparam int DEBOUNCE_W = 20;
	localparam int ASCII_W    = 7;
	localparam int ROW_W      = $clog2(ROWS);
	localparam int KEY_W      = $clog2(KEYS);
	localparam int CFG_DATA_W = DEBOUNCE_W;

	localparam logic [SETTLE_W-1:0]   SETTLE_RESET   = SETTLE_W'(2);
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(80000);

	localparam logic CFG_SETTLE   = 1'b0;
	localparam logic CFG_DEBOUNCE = 1'b1;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_WAIT   = 2'd1,
		PH_SECOND = 2'd2
	} phase_t;

	typedef struct packed {
		logic [ROWS-1:0]    row_drive;
		logic               key_valid;
		logic [ASCII_W-1:0] key_ascii;
	} res_t;

	function automatic logic [ASCII_W-1:0] key_char(input logic [KEY_W-1:0] idx);
		logic [ASCII_W-1:0] c;
		case (idx)
			4'd0:    c = ASCII_W'("*");
			4'd1:    c = ASCII_W'("0");
			4'd2:    c = ASCII_W'("#");
			4'd3:    c = ASCII_W'("D");
			4'd4:    c = ASCII_W'("7");
			4'd5:    c = ASCII_W'("8");
			4'd6:    c = ASCII_W'("9");
			4'd7:    c = ASCII_W'("C");
			4'd8:    c = ASCII_W'("4");
			4'd9:    c = ASCII_W'("5");
			4'd10:   c = ASCII_W'("6");
			4'd11:   c = ASCII_W'("B");
			4'd12:   c = ASCII_W'("1");
			4'd13:   c = ASCII_W'("2");
			4'd14:   c = ASCII_W'("3");
			default: c = ASCII_W'("A");
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/kpsc_prio_enc.sv =====
// Lowest-set-bit priority encoder mapping a fresh key word to ASCII.
`default_nettype none
module kpsc_prio_enc (
	input  wire logic [kpsc_pkg::KEYS-1:0]    fresh,
	output      logic                         hit,
	output      logic [kpsc_pkg::ASCII_W-1:0] ascii
);
	import kpsc_pkg::*;

	logic [KEY_W-1:0] idx;

	always_comb begin
		idx = '0;
		for (int b = KEYS - 1; b >= 0; b--) begin
			if (fresh[b]) begin
				idx = KEY_W'(b);
			end
		end
		hit   = |fresh;
		ascii = hit ? key_char(idx) : '0;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/kpsc_scan_ctrl.sv =====
// Row sequencer, settle/debounce counters and snapshot registers.
`default_nettype none
module kpsc_scan_ctrl (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            step,
	input  wire logic [kpsc_pkg::COLS-1:0]       cols,
	input  wire logic [kpsc_pkg::SETTLE_W-1:0]   settle_ticks,
	input  wire logic [kpsc_pkg::DEBOUNCE_W-1:0] debounce_ticks,
	output      kpsc_pkg::res_t                  res
);
	import kpsc_pkg::*;

	phase_t              phase_q, phase_d;
	logic [ROW_W-1:0]    row_q, row_d;
	logic [SETTLE_W-1:0] settle_q, settle_d;
	logic [DEBOUNCE_W-1:0] wait_q, wait_d;
	logic [KEYS-1:0]     build_q, build_d;
	logic [KEYS-1:0]     first_q, first_d;
	logic [KEYS-1:0]     prev_q, prev_d;

	logic [KEYS-1:0]     build_new;
	logic [KEYS-1:0]     deb;
	logic [KEYS-1:0]     fresh;
	logic                hit;
	logic [ASCII_W-1:0]  ascii;

	kpsc_prio_enc u_enc (
		.fresh (fresh),
		.hit   (hit),
		.ascii (ascii)
	);

	// row r lands in nibble (ROWS-1-r)
	always_comb begin
		build_new = build_q;
		for (int r = 0; r < ROWS; r++) begin
			if (row_q == ROW_W'(r)) begin
				build_new[(ROWS-1-r)*COLS +: COLS] = cols;
			end
		end
		deb   = first_q & build_new;
		fresh = deb & ~prev_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			row_q    <= '0;
			settle_q <= '0;
			wait_q   <= '0;
			build_q  <= '0;
			first_q  <= '0;
			prev_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			row_q    <= row_d;
			settle_q <= settle_d;
			wait_q   <= wait_d;
			build_q  <= build_d;
			first_q  <= first_d;
			prev_q   <= prev_d;
		end
	end

	always_comb begin
		phase_d       = phase_q;
		row_d         = row_q;
		settle_d      = settle_q;
		wait_d        = wait_q;
		build_d       = build_q;
		first_d       = first_q;
		prev_d        = prev_q;
		res.row_drive = '0;
		res.key_valid = 1'b0;
		res.key_ascii = '0;
		unique case (phase_q)
			PH_WAIT: begin
				if (wait_q >= debounce_ticks) begin
					wait_d   = '0;
					phase_d  = PH_SECOND;
					row_d    = '0;
					settle_d = '0;
					build_d  = '0;
				end else begin
					wait_d = wait_q + DEBOUNCE_W'(1);
				end
			end
			default: begin
				res.row_drive = ROWS'(1) << row_q;
				if (settle_q >= settle_ticks) begin
					settle_d = '0;
					build_d  = build_new;
					row_d    = row_q + ROW_W'(1);
					if (row_q == ROW_W'(ROWS - 1)) begin
						build_d = '0;
						if (phase_q == PH_SECOND) begin
							prev_d        = deb;
							res.key_valid = hit;
							res.key_ascii = ascii;
							phase_d       = PH_FIRST;
						end else begin
							first_d = build_new;
							phase_d = PH_WAIT;
							wait_d  = '0;
						end
					end
				end else begin
					settle_d = settle_q + SETTLE_W'(1);
				end
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/keypad_scan_debounce_edge_ascii.sv =====
// Top level: config registers, input register, scan control and result register.
// Each request is held in the input register, then stepped through scan control into the result register.
// Throughput: one request per cycle while out_ready does not stall the result; the scan
// state updates once per request through the row sequencer and counters.
// Reset: arst_n clears all control and snapshot state, loads settle 2 and
// debounce 80000; no clearing pass.
`default_nettype none
module keypad_scan_debounce_edge_ascii (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output      logic                            in_ready,
	input  wire logic [kpsc_pkg::COLS-1:0]       column_sense,
	output      logic                            out_valid,
	input  wire logic                            out_ready,
	output      logic [kpsc_pkg::ROWS-1:0]       row_drive,
	output      logic                            key_valid,
	output      logic [kpsc_pkg::ASCII_W-1:0]    key_ascii,
	input  wire logic                            cfg_valid,
	output      logic                            cfg_ready,
	input  wire logic                            cfg_index,
	input  wire logic [kpsc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import kpsc_pkg::*;

	logic [SETTLE_W-1:0]   settle_q;
	logic [DEBOUNCE_W-1:0] debounce_q;
	logic                  valid_s1;
	logic [COLS-1:0]       cols_s1;
	logic                  out_valid_q;
	res_t                  res;
	res_t                  res_q;
	logic                  step;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q   <= SETTLE_RESET;
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SETTLE:   settle_q   <= cfg_data[SETTLE_W-1:0];
				CFG_DEBOUNCE: debounce_q <= cfg_data[DEBOUNCE_W-1:0];
				default:      ;
			endcase
		end
	end

	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cols_s1 <= column_sense;
		end
	end

	kpsc_scan_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.cols           (cols_s1),
		.settle_ticks   (settle_q),
		.debounce_ticks (debounce_q),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign row_drive = res_q.row_drive;
	assign key_valid = res_q.key_valid;
	assign key_ascii = res_q.key_ascii;

endmodule
`default_nettype wire

// ===== hw/rtl/kpsc_checker.sv =====
// Port-level checks for the keypad scanner, bound to the top level.
`default_nettype none
module kpsc_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic [kpsc_pkg::ROWS-1:0]    row_drive,
	input wire logic                         key_valid,
	input wire logic [kpsc_pkg::ASCII_W-1:0] key_ascii
);
	import kpsc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(row_drive) && $stable(key_valid)
			&& $stable(key_ascii))
		else $error("result changed while stalled");

	a_row_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(row_drive))
		else $error("row drive not one-hot");

	a_key_on_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_valid |-> row_drive == ROWS'(1) << (ROWS - 1))
		else $error("key reported off the last row");

	a_key_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_valid |-> key_ascii != '0)
		else $error("key reported with null code");

	a_no_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !key_valid |-> key_ascii == '0)
		else $error("code without key");

endmodule

bind keypad_scan_debounce_edge_ascii kpsc_checker u_kpsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.row_drive (row_drive),
	.key_valid (key_valid),
	.key_ascii (key_ascii)
);
`default_nettype wire
